// ===== sv/i2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  kind;
    logic        with_prefix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  localparam logic [1:0] KIND_BIN = 2'd0;
  localparam logic [1:0] KIND_HEX = 2'd1;
  localparam logic [1:0] KIND_DEC = 2'd2;
  localparam logic [1:0] KIND_RAW = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_B    = 8'h62;
  localparam logic [7:0] ASCII_X    = 8'h78;
  localparam logic [7:0] ASCII_NUL  = 8'h00;

  localparam logic [3:0] DEC_LAST_IDX = 4'd9;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic adv;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       need_pre;
    logic [7:0] pre_ch;
    logic       has_char;
    logic [7:0] ch;
    logic       last_step;
  } dp_stat_t;

  function automatic logic [31:0] dec_weight(input logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd0:    w = 32'd1000000000;
      4'd1:    w = 32'd100000000;
      4'd2:    w = 32'd10000000;
      4'd3:    w = 32'd1000000;
      4'd4:    w = 32'd100000;
      4'd5:    w = 32'd10000;
      4'd6:    w = 32'd1000;
      4'd7:    w = 32'd100;
      4'd8:    w = 32'd10;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib <= 4'd9) begin
      c = ASCII_ZERO + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2a_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2a_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire i2a_pkg::in_item_t in_data,
  input  wire i2a_pkg::dp_cmd_t  cmd,
  output i2a_pkg::dp_stat_t      stat
);
  import i2a_pkg::*;

  logic [31:0] val_r, val_nxt;
  logic [1:0]  kind_r;
  logic        pre_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        seen_r, seen_nxt;
  logic        hi_emit_r, hi_emit_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic [3:0]  widx_r, widx_nxt;

  logic [31:0] weight;
  logic        ge;
  logic        emit;
  logic [7:0]  ch;
  logic        last_step;

  assign weight = dec_weight(widx_r);
  assign ge     = (val_r >= weight);

  always_comb begin
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    seen_nxt    = seen_r;
    hi_emit_nxt = hi_emit_r;
    digit_nxt   = digit_r;
    widx_nxt    = widx_r;
    emit        = 1'b0;
    ch          = ASCII_NUL;
    last_step   = 1'b0;
    case (kind_r)
      KIND_BIN: begin
        seen_nxt  = seen_r | val_r[31];
        emit      = seen_nxt || (cnt_r == 5'd31);
        ch        = val_r[31] ? ASCII_ONE : ASCII_ZERO;
        val_nxt   = {val_r[30:0], 1'b0};
        cnt_nxt   = cnt_r + 5'd1;
        last_step = (cnt_r == 5'd31);
      end
      KIND_HEX: begin
        ch      = nibble_char(val_r[31:28]);
        val_nxt = {val_r[27:0], 4'h0};
        cnt_nxt = cnt_r + 5'd1;
        if (!cnt_r[0]) begin
          // high nibble decides for the whole byte
          seen_nxt    = seen_r | (val_r[31:24] != 8'h00);
          emit        = seen_nxt || (cnt_r[2:1] == 2'd3);
          hi_emit_nxt = emit;
        end else begin
          emit = hi_emit_r;
        end
        last_step = (cnt_r[2:0] == 3'd7);
      end
      KIND_DEC: begin
        if (ge) begin
          val_nxt   = val_r - weight;
          digit_nxt = digit_r + 4'd1;
        end else begin
          seen_nxt  = seen_r | (digit_r != 4'd0);
          emit      = seen_nxt || (widx_r == DEC_LAST_IDX);
          ch        = ASCII_ZERO + {4'h0, digit_r};
          digit_nxt = 4'd0;
          widx_nxt  = widx_r + 4'd1;
          last_step = (widx_r == DEC_LAST_IDX);
        end
      end
      default: begin
        emit      = (val_r[31:8] == 24'h000000);
        ch        = val_r[7:0];
        last_step = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      seen_r    <= 1'b0;
      hi_emit_r <= 1'b0;
      digit_r   <= '0;
      widx_r    <= '0;
      kind_r    <= KIND_BIN;
      pre_r     <= 1'b0;
    end else if (cmd.load) begin
      cnt_r     <= '0;
      seen_r    <= 1'b0;
      hi_emit_r <= 1'b0;
      digit_r   <= '0;
      widx_r    <= '0;
      kind_r    <= in_data.kind;
      pre_r     <= in_data.with_prefix;
    end else if (cmd.adv) begin
      cnt_r     <= cnt_nxt;
      seen_r    <= seen_nxt;
      hi_emit_r <= hi_emit_nxt;
      digit_r   <= digit_nxt;
      widx_r    <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_data.value;
    end else if (cmd.adv) begin
      val_r <= val_nxt;
    end
  end

  assign stat.need_pre  = pre_r && ((kind_r == KIND_BIN) || (kind_r == KIND_HEX));
  assign stat.pre_ch    = (kind_r == KIND_HEX) ? ASCII_X : ASCII_B;
  assign stat.has_char  = emit;
  assign stat.ch        = ch;
  assign stat.last_step = last_step;

endmodule

`default_nettype wire

// ===== sv/i2a_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2a_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2a_pkg::out_item_t      out_data,
  output i2a_pkg::dp_cmd_t        cmd,
  input  wire i2a_pkg::dp_stat_t  stat
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE0,
    ST_PRE1,
    ST_DIGITS,
    ST_TERM
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      slot_free;
  logic      emit;
  out_item_t emit_item;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    emit_item = '{character: ASCII_NUL, last: 1'b0};
    cmd       = '{load: 1'b0, adv: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRE0;
        end
      end
      ST_PRE0: begin
        if (!stat.need_pre) begin
          state_nxt = ST_DIGITS;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_item = '{character: ASCII_ZERO, last: 1'b0};
          state_nxt = ST_PRE1;
        end
      end
      ST_PRE1: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_item = '{character: stat.pre_ch, last: 1'b0};
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (!stat.has_char || slot_free) begin
          cmd.adv   = 1'b1;
          emit      = stat.has_char;
          emit_item = '{character: stat.ch, last: 1'b0};
          if (stat.last_step) begin
            state_nxt = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_item = '{character: ASCII_NUL, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= emit_item;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// Channel   Direction  Payload               Handshake
// in_       input      value, kind, prefix   in_valid / in_ready
// out_      output     character, last       out_valid / out_ready
//
// One value in gives its text out, one character per item, closed by a
// zero terminator with last set. Per value the sequencer accepts it, checks
// for a prefix (giving two characters when one is asked for), runs the digit
// steps for binary, hex, decimal or raw, then gives the terminator. Decimal
// digits come from repeated steps of the single compare-and-subtract.
// Reset is synchronous, active low, and clears the sequencer and out_valid.
// A stalled output holds the sequencer on steps that give a character; a new
// value is taken once the terminator sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2a_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2a_pkg::out_item_t      out_data
);
  import i2a_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: prefix, digit steps, terminator; owns the output register
  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // shift / subtract datapath, one digit step per advance
  i2a_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat)
  );

  // an accepted item makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous value still in progress");

  // the terminator is always a zero character
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.character == ASCII_NUL))
    else $error("terminator carries non-zero character");

  // a digit step and a load never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.adv))
    else $error("datapath load and advance together");

  // output register empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
